>>> rtl/core/dmdf_pkg.sv
// Shared types, constants and helper functions of the directional
// minimum-difference filter. No dependencies; every other file imports it.
`default_nettype none

package dmdf_pkg;

   // Default store dimensions.
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   // Coordinate width: effective frame sizes reach 256, so frame sizes and
   // clamped coordinates are held in nine bits.
   localparam int CRD_W = 9;
   // Signed width for neighbour arithmetic (covers -510 .. 1020).
   localparam int NB_W  = 12;
   localparam int PIX_W = 8;

   // Configuration port.
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 9;

   localparam logic [CFG_IDX_W-1:0] CSR_FRAME_WIDTH   = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CSR_FRAME_HEIGHT  = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CSR_PITCH_X       = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CSR_PITCH_Y       = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CSR_REGION_LEFT   = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CSR_REGION_TOP    = 3'd5;
   localparam logic [CFG_IDX_W-1:0] CSR_REGION_RIGHT  = 3'd6;
   localparam logic [CFG_IDX_W-1:0] CSR_REGION_BOTTOM = 3'd7;

   // Operation codes of an input word.
   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   // Status codes of a result word.
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_UNINSPECTED = 2'd1;
   localparam logic [1:0] STATUS_PITCH       = 2'd2;

   // Direction codes.
   localparam logic [1:0] DIR_H    = 2'd0;
   localparam logic [1:0] DIR_V    = 2'd1;
   localparam logic [1:0] DIR_D45  = 2'd2;
   localparam logic [1:0] DIR_D135 = 2'd3;

   // Output level constants.
   localparam int MID_LEVEL = 128;
   localparam int MAX_LEVEL = 255;

   // Neighbour pixel fetch: eight reads after the centre.
   localparam int NB_PIX    = 8;
   localparam int PIX_IDX_W = 3;
   localparam int PIX_CNT_W = 4;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CLAMP,
      ST_RDC,
      ST_CHKC,
      ST_IL,
      ST_IR,
      ST_IT,
      ST_IB,
      ST_PIX,
      ST_SEL,
      ST_FIN
   } dmdf_state_type;

   // Status of the frame store seen by the sequencer.
   typedef struct packed {
      logic clear_busy;
   } dmdf_store_stat_type;

   // Widen an unsigned coordinate or offset into the signed working width.
   function automatic logic signed [NB_W-1:0] to_signed(input logic [CRD_W-1:0] v);
      return $signed(NB_W'(v));
   endfunction

   // Clamp a signed coordinate into 0 .. dim-1.
   function automatic logic [CRD_W-1:0] clamp_coord(input logic signed [NB_W-1:0] v,
                                                    input logic [CRD_W-1:0] dim);
      logic signed [NB_W-1:0] lim;
      lim = $signed(NB_W'(dim)) - $signed(NB_W'(1));
      if (v < 0) begin
         return '0;
      end else if (v > lim) begin
         return lim[CRD_W-1:0];
      end else begin
         return v[CRD_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/dmdf_store.sv
// Frame store and inspection map of the filter, each a synchronous memory
// with one write and one registered read port. Depends on dmdf_pkg.
`default_nettype none

module dmdf_store #(
   parameter int DEPTH  = dmdf_pkg::DEF_MAX_WIDTH * dmdf_pkg::DEF_MAX_HEIGHT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_en,
   input  wire logic [ADDR_W-1:0]            wr_addr,
   input  wire logic [dmdf_pkg::PIX_W-1:0]   wr_pixel,
   input  wire logic                         wr_flag,
   input  wire logic [ADDR_W-1:0]            pix_rd_addr,
   input  wire logic [ADDR_W-1:0]            insp_rd_addr,
   output logic      [dmdf_pkg::PIX_W-1:0]   pix_rd_data,
   output logic                              insp_rd_data,
   output dmdf_pkg::dmdf_store_stat_type     stat
);
   import dmdf_pkg::*;

   logic [PIX_W-1:0]  pixel_mem [DEPTH];
   logic              insp_mem  [DEPTH];

   logic [ADDR_W-1:0] clr_addr_ff;
   logic              clr_busy_ff;
   logic [PIX_W-1:0]  pix_rd_ff;
   logic              insp_rd_ff;

   // Clearing sweep of the inspection map, one entry per cycle after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Pixel memory: no reset contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pixel_mem[wr_addr] <= wr_pixel;
      end
      pix_rd_ff <= pixel_mem[pix_rd_addr];
   end

   // Inspection map: the sweep owns the write port while it runs.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         insp_mem[clr_addr_ff] <= 1'b0;
      end else if (wr_en) begin
         insp_mem[wr_addr] <= wr_flag;
      end
      insp_rd_ff <= insp_mem[insp_rd_addr];
   end

   assign pix_rd_data     = pix_rd_ff;
   assign insp_rd_data    = insp_rd_ff;
   assign stat.clear_busy = clr_busy_ff;

endmodule

`default_nettype wire

>>> rtl/core/directional_min_diff_filter_top.sv
// Top level of the directional minimum-difference filter: configuration
// registers, the per-word sequencer and the result register. Depends on
// dmdf_pkg and dmdf_store.
//
// The block holds a frame of 8-bit pixels and a one-bit inspection map.
// A write word stores one pixel and its map bit at acceptance. A compute
// word walks through a fixed sequence: a step to latch and clamp the
// centre, one read of centre pixel and map bit, four map reads for the
// left, right, top and bottom neighbours, eight pixel reads for the
// neighbour ends, a step to pick the direction and one to form the
// result, which waits while the result register is full. Each memory
// has a single read port. A word that ends early (pitch too large,
// centre not inspected) skips to the result step. A finished result
// waits in its own register, so the next word can be accepted while it
// is pending. After reset the inspection map is cleared, one entry per
// cycle over MAX_WIDTH*MAX_HEIGHT entries (65536 with the defaults); no
// word is accepted during that sweep, though configuration writes are.
`default_nettype none

module directional_min_diff_filter_top #(
   parameter int MAX_WIDTH  = dmdf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = dmdf_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Configuration port.
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [dmdf_pkg::CFG_IDX_W-1:0]     csr_index,
   input  wire logic [dmdf_pkg::CFG_DATA_W-1:0]    csr_data,
   // Input channel.
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_operation,
   input  wire logic [7:0]                         req_pos_x,
   input  wire logic [7:0]                         req_pos_y,
   input  wire logic [7:0]                         req_pixel_value,
   input  wire logic                               req_inspect_flag,
   // Result channel.
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [7:0]                              rsp_out_value,
   output logic [1:0]                              rsp_status,
   output logic [1:0]                              rsp_chosen_direction
);
   import dmdf_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   // Linear store address of a coordinate pair.
   function automatic logic [ADDR_W-1:0] addr_of(input logic [CRD_W-1:0] x,
                                                 input logic [CRD_W-1:0] y);
      return ADDR_W'(y * MAX_WIDTH + x);
   endfunction

   // Magnitude of a pixel difference.
   function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] p,
                                                 input logic [PIX_W-1:0] q);
      return (p >= q) ? (p - q) : (q - p);
   endfunction

   // Configuration registers.
   logic [8:0] frame_width_ff, frame_height_ff;
   logic [7:0] pitch_x_ff, pitch_y_ff, region_left_ff, region_top_ff;
   logic [8:0] region_right_ff, region_bottom_ff;

   dmdf_state_type state_ff, state_in;

   // Working registers of one compute word.
   logic [7:0]          pos_x_ff, pos_y_ff;
   logic [CRD_W-1:0]    x_ff, y_ff, lp_ff, rp_ff, tp_ff, bp_ff;
   logic [PIX_W-1:0]    a_ff;
   logic [PIX_W-1:0]    nb_ff [NB_PIX];
   logic [PIX_CNT_W-1:0] pix_cnt_ff;
   logic [1:0]          status_ff, bi_ff;
   logic [PIX_W:0]      sum_ff;

   // Result register.
   logic             rsp_valid_ff;
   logic [7:0]       rsp_value_ff;
   logic [1:0]       rsp_status_ff, rsp_dir_ff;

   // Store connections.
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr, pix_rd_addr, insp_rd_addr;
   logic [PIX_W-1:0]    pix_rd_data;
   logic                insp_rd_data;
   dmdf_store_stat_type store_stat;

   logic req_accept, out_free, pitch_bad;
   logic [CRD_W-1:0] fw, fh;
   logic [CRD_W-1:0] l_first, r_first, t_first, b_first;
   logic [CRD_W-1:0] l_alt, r_alt, t_alt, b_alt;
   logic [CRD_W-1:0] px_sel_x, px_sel_y;
   logic [PIX_IDX_W-1:0] cap_idx;
   logic [PIX_W-1:0] d0, d1, d2, d3, best;
   logic [1:0]       bi_sel;
   logic [PIX_W:0]   sum_sel;
   logic signed [NB_W-1:0] val_s;
   logic [7:0]       val_clamped;
   logic signed [NB_W-1:0] xs, ys, dxs, dys;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= 9'd256;
         frame_height_ff  <= 9'd256;
         pitch_x_ff       <= 8'd1;
         pitch_y_ff       <= 8'd1;
         region_left_ff   <= 8'd0;
         region_top_ff    <= 8'd0;
         region_right_ff  <= 9'd256;
         region_bottom_ff <= 9'd256;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH:   frame_width_ff   <= csr_data;
            CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_data;
            CSR_PITCH_X:       pitch_x_ff       <= csr_data[7:0];
            CSR_PITCH_Y:       pitch_y_ff       <= csr_data[7:0];
            CSR_REGION_LEFT:   region_left_ff   <= csr_data[7:0];
            CSR_REGION_TOP:    region_top_ff    <= csr_data[7:0];
            CSR_REGION_RIGHT:  region_right_ff  <= csr_data;
            CSR_REGION_BOTTOM: region_bottom_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Effective frame size: at least one, at most the store size.
   always_comb begin
      if (frame_width_ff == '0) begin
         fw = CRD_W'(1);
      end else if (frame_width_ff > MAX_WIDTH) begin
         fw = CRD_W'(MAX_WIDTH);
      end else begin
         fw = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         fh = CRD_W'(1);
      end else if (frame_height_ff > MAX_HEIGHT) begin
         fh = CRD_W'(MAX_HEIGHT);
      end else begin
         fh = frame_height_ff;
      end
   end

   // A pitch is too large when three steps reach the frame edge.
   assign pitch_bad = ((10'(pitch_x_ff) + 10'({pitch_x_ff, 1'b0})) >= 10'(frame_width_ff)) ||
                      ((10'(pitch_y_ff) + 10'({pitch_y_ff, 1'b0})) >= 10'(frame_height_ff));

   // First-choice neighbours and their fallbacks at twice the pitch.
   assign xs  = to_signed(x_ff);
   assign ys  = to_signed(y_ff);
   assign dxs = $signed(NB_W'(pitch_x_ff));
   assign dys = $signed(NB_W'(pitch_y_ff));

   assign l_alt = clamp_coord(xs + dxs + dxs, fw);
   assign r_alt = clamp_coord(xs - dxs - dxs, fw);
   assign t_alt = clamp_coord(ys + dys + dys, fh);
   assign b_alt = clamp_coord(ys - dys - dys, fh);

   assign l_first = (xs - dxs >= $signed(NB_W'(region_left_ff))) ?
                    clamp_coord(xs - dxs, fw) : l_alt;
   assign r_first = (xs + dxs < $signed(NB_W'(region_right_ff))) ?
                    clamp_coord(xs + dxs, fw) : r_alt;
   assign t_first = (ys - dys >= $signed(NB_W'(region_top_ff))) ?
                    clamp_coord(ys - dys, fh) : t_alt;
   assign b_first = (ys + dys < $signed(NB_W'(region_bottom_ff))) ?
                    clamp_coord(ys + dys, fh) : b_alt;

   // Coordinates of the neighbour pixel read issued this cycle.
   always_comb begin
      case (pix_cnt_ff[PIX_IDX_W-1:0])
         3'd0:    begin px_sel_x = lp_ff; px_sel_y = y_ff;  end
         3'd1:    begin px_sel_x = rp_ff; px_sel_y = y_ff;  end
         3'd2:    begin px_sel_x = x_ff;  px_sel_y = tp_ff; end
         3'd3:    begin px_sel_x = x_ff;  px_sel_y = bp_ff; end
         3'd4:    begin px_sel_x = lp_ff; px_sel_y = tp_ff; end
         3'd5:    begin px_sel_x = lp_ff; px_sel_y = bp_ff; end
         3'd6:    begin px_sel_x = rp_ff; px_sel_y = tp_ff; end
         3'd7:    begin px_sel_x = rp_ff; px_sel_y = bp_ff; end
         default: begin px_sel_x = x_ff;  px_sel_y = y_ff;  end
      endcase
   end

   assign cap_idx = PIX_IDX_W'(pix_cnt_ff - PIX_CNT_W'(1));

   // Direction choice: the smallest difference, earliest on a tie.
   always_comb begin
      d0 = abs_diff(nb_ff[0], nb_ff[1]);
      d1 = abs_diff(nb_ff[2], nb_ff[3]);
      d2 = abs_diff(nb_ff[5], nb_ff[6]);
      d3 = abs_diff(nb_ff[4], nb_ff[7]);
      best   = d0;
      bi_sel = DIR_H;
      if (d1 < best) begin
         best   = d1;
         bi_sel = DIR_V;
      end
      if (d2 < best) begin
         best   = d2;
         bi_sel = DIR_D45;
      end
      if (d3 < best) begin
         bi_sel = DIR_D135;
      end
      case (bi_sel)
         DIR_H:    sum_sel = {1'b0, nb_ff[0]} + {1'b0, nb_ff[1]};
         DIR_V:    sum_sel = {1'b0, nb_ff[2]} + {1'b0, nb_ff[3]};
         DIR_D45:  sum_sel = {1'b0, nb_ff[5]} + {1'b0, nb_ff[6]};
         DIR_D135: sum_sel = {1'b0, nb_ff[4]} + {1'b0, nb_ff[7]};
         default:  sum_sel = '0;
      endcase
   end

   // Filtered value, clamped to the byte range.
   assign val_s = $signed(NB_W'(MID_LEVEL)) + $signed(NB_W'({a_ff, 1'b0}))
                  - $signed(NB_W'(sum_ff));
   always_comb begin
      if (val_s < 0) begin
         val_clamped = '0;
      end else if (val_s > $signed(NB_W'(MAX_LEVEL))) begin
         val_clamped = 8'(MAX_LEVEL);
      end else begin
         val_clamped = val_s[7:0];
      end
   end

   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Store writes happen straight at acceptance; out-of-store writes drop.
   assign wr_en   = req_accept && (req_operation == OP_WRITE) &&
                    (req_pos_x < MAX_WIDTH) && (req_pos_y < MAX_HEIGHT);
   assign wr_addr = addr_of(CRD_W'(req_pos_x), CRD_W'(req_pos_y));

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state, handshake and read addresses.
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      pix_rd_addr  = addr_of(x_ff, y_ff);
      insp_rd_addr = addr_of(x_ff, y_ff);
      case (state_ff)
         ST_CLEAR: begin
            if (!store_stat.clear_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_operation == OP_COMPUTE) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            state_in = pitch_bad ? ST_FIN : ST_RDC;
         end
         ST_RDC: begin
            state_in = ST_CHKC;
         end
         ST_CHKC: begin
            insp_rd_addr = addr_of(lp_ff, y_ff);
            state_in     = insp_rd_data ? ST_IL : ST_FIN;
         end
         ST_IL: begin
            insp_rd_addr = addr_of(rp_ff, y_ff);
            state_in     = ST_IR;
         end
         ST_IR: begin
            insp_rd_addr = addr_of(x_ff, tp_ff);
            state_in     = ST_IT;
         end
         ST_IT: begin
            insp_rd_addr = addr_of(x_ff, bp_ff);
            state_in     = ST_IB;
         end
         ST_IB: begin
            state_in = ST_PIX;
         end
         ST_PIX: begin
            pix_rd_addr = addr_of(px_sel_x, px_sel_y);
            if (pix_cnt_ff == PIX_CNT_W'(NB_PIX)) begin
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Working registers of the compute sequence.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            pos_x_ff <= req_pos_x;
            pos_y_ff <= req_pos_y;
         end
         ST_CLAMP: begin
            x_ff      <= clamp_coord(to_signed(CRD_W'(pos_x_ff)), fw);
            y_ff      <= clamp_coord(to_signed(CRD_W'(pos_y_ff)), fh);
            status_ff <= pitch_bad ? STATUS_PITCH : STATUS_OK;
         end
         ST_RDC: begin
            lp_ff <= l_first;
            rp_ff <= r_first;
            tp_ff <= t_first;
            bp_ff <= b_first;
         end
         ST_CHKC: begin
            a_ff      <= pix_rd_data;
            status_ff <= insp_rd_data ? STATUS_OK : STATUS_UNINSPECTED;
         end
         ST_IL: begin
            if (!insp_rd_data) begin
               lp_ff <= l_alt;
            end
         end
         ST_IR: begin
            if (!insp_rd_data) begin
               rp_ff <= r_alt;
            end
         end
         ST_IT: begin
            if (!insp_rd_data) begin
               tp_ff <= t_alt;
            end
         end
         ST_IB: begin
            if (!insp_rd_data) begin
               bp_ff <= b_alt;
            end
            pix_cnt_ff <= '0;
         end
         ST_PIX: begin
            pix_cnt_ff <= pix_cnt_ff + PIX_CNT_W'(1);
            if (pix_cnt_ff != '0) begin
               nb_ff[cap_idx] <= pix_rd_data;
            end
         end
         ST_SEL: begin
            bi_ff  <= bi_sel;
            sum_ff <= sum_sel;
         end
         default: begin
         end
      endcase
   end

   // Result register: loaded at the end of a compute word.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FIN && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN && out_free) begin
         rsp_status_ff <= status_ff;
         if (status_ff == STATUS_OK) begin
            rsp_value_ff <= val_clamped;
            rsp_dir_ff   <= bi_ff;
         end else begin
            rsp_value_ff <= '0;
            rsp_dir_ff   <= DIR_H;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_value        = rsp_value_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_chosen_direction = rsp_dir_ff;

   dmdf_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_pixel     (req_pixel_value),
      .wr_flag      (req_inspect_flag),
      .pix_rd_addr  (pix_rd_addr),
      .insp_rd_addr (insp_rd_addr),
      .pix_rd_data  (pix_rd_data),
      .insp_rd_data (insp_rd_data),
      .stat         (store_stat)
   );

endmodule

`default_nettype wire

>>> rtl/core/dmdf_checker.sv
// Port-level checks of the directional minimum-difference filter, bound to
// the top level. Depends on dmdf_pkg and directional_min_diff_filter_top.
`default_nettype none

module dmdf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_operation,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_value,
   input wire logic [1:0] rsp_status,
   input wire logic [1:0] rsp_chosen_direction
);
   import dmdf_pkg::*;

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_value) &&
      $stable(rsp_status) && $stable(rsp_chosen_direction))
      else $error("result word changed while stalled");

   // An error status carries a zero value and the horizontal code.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |->
      rsp_out_value == 8'd0 && rsp_chosen_direction == DIR_H)
      else $error("error result with non-zero payload");

   // Only the three defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_OK || rsp_status == STATUS_UNINSPECTED ||
                    rsp_status == STATUS_PITCH)
      else $error("undefined status code");

   // A compute word occupies the block for at least the next cycle.
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_COMPUTE |=> !req_ready)
      else $error("input taken right after a compute word");

   // Reset empties the result side and starts the map sweep.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block not quiet after reset");

endmodule

bind directional_min_diff_filter_top dmdf_checker u_dmdf_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .req_operation        (req_operation),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_out_value        (rsp_out_value),
   .rsp_status           (rsp_status),
   .rsp_chosen_direction (rsp_chosen_direction)
);

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench of the directional minimum-difference filter.
// Drives words, configuration writes and result stalls around directional_min_diff_filter_top.
// It checks every result word against a directed value or a predictor. Depends on dmdf_pkg.
module tb_top;
   import dmdf_pkg::*;

   localparam int MAX_W         = DEF_MAX_WIDTH;
   localparam int MAX_H         = DEF_MAX_HEIGHT;
   localparam int IDLE_PCT      = 23;
   localparam int SETTLE_CYCLES = 32;
   localparam int RANDOM_WORDS  = 800;
   localparam int REPORT_LIMIT  = 10;
   localparam int NO_DIFF       = 9999;
   localparam int CALM_PHASE    = 4;
   localparam int SCRIPT_ROWS   = 26;
   localparam logic [1:0] DIR_ORDER [4] = '{DIR_H, DIR_V, DIR_D45, DIR_D135};

   typedef struct packed {
      logic [7:0] level;
      logic [1:0] status;
      logic [1:0] direction;
   } filter_result_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic                     op;
      logic [7:0]               x;
      logic [7:0]               y;
      logic [7:0]               value;
      logic                     flag;
      bit                       known;
      filter_result_type        want;
      logic [CFG_IDX_W-1:0]     idx;
      logic [CFG_DATA_W-1:0]    data;
   } stim_row_type;

   // Ports of the block; every input is known from time zero.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CFG_IDX_W-1:0]  csr_index = '0;
   logic [CFG_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_operation = OP_WRITE;
   logic [7:0]            req_pos_x = '0;
   logic [7:0]            req_pos_y = '0;
   logic [7:0]            req_pixel_value = '0;
   logic                  req_inspect_flag = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_out_value;
   logic [1:0]            rsp_status;
   logic [1:0]            rsp_chosen_direction;

   // Mirror of the block's registers and stores.
   int   frame_w = 256, frame_h = 256, step_x = 1, step_y = 1;
   int   roi_left = 0, roi_top = 0, roi_right = 256, roi_bottom = 256;
   logic [7:0] pixel_mem [MAX_W*MAX_H];
   bit         map_mem   [MAX_W*MAX_H];
   bit         written   [MAX_W*MAX_H];

   // Pixel addresses that the last prediction read.
   int unsigned touched [9];
   int          n_touched;

   filter_result_type pending_results [$];
   int                error_count = 0;
   int                words_sent = 0;
   bit                calm = 1'b0;

   directional_min_diff_filter_top dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_pixel_value     (req_pixel_value),
      .req_inspect_flag    (req_inspect_flag),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_value       (rsp_out_value),
      .rsp_status          (rsp_status),
      .rsp_chosen_direction(rsp_chosen_direction)
   );

   always #2 clock = ~clock;

   // Clamp helpers of the predictor.
   function automatic int extent(input int v, input int cap);
      return (v < 1) ? 1 : ((v > cap) ? cap : v);
   endfunction

   function automatic int fit(input int v, input int dim);
      return (v < 0) ? 0 : ((v > dim - 1) ? dim - 1 : v);
   endfunction

   function automatic int unsigned store_addr(input int x, input int y);
      return y * MAX_W + x;
   endfunction

   // Reads a stored pixel and notes its address.
   function automatic int take_pixel(input int x, input int y);
      touched[n_touched] = store_addr(x, y);
      n_touched++;
      return int'(pixel_mem[store_addr(x, y)]);
   endfunction

   // Works out the result word of a compute word from the mirrored state.
   function automatic filter_result_type predict_filter(input logic [7:0] px,
                                                        input logic [7:0] py);
      filter_result_type res;
      int fwe, fhe, x, y, dx, dy, lp, rp, tp, bp;
      int c, l, r, t, b, lt, lb, rt, rb, best, pick, acc, k, mag;
      int diff [4];
      int sums [4];
      res.level = '0;
      res.status = STATUS_OK;
      res.direction = DIR_H;
      n_touched = 0;
      // An oversized pitch is reported before anything is read.
      if (step_x * 3 >= frame_w || step_y * 3 >= frame_h) begin
         res.status = STATUS_PITCH;
         return res;
      end
      fwe = extent(frame_w, MAX_W);
      fhe = extent(frame_h, MAX_H);
      x = fit(int'(px), fwe);
      y = fit(int'(py), fhe);
      dx = step_x;
      dy = step_y;
      c = take_pixel(x, y);
      if (!map_mem[store_addr(x, y)]) begin
         res.status = STATUS_UNINSPECTED;
         return res;
      end
      // Neighbours leaving the region fall back to the far side at twice the pitch.
      lp = fit((x - dx >= roi_left) ? x - dx : x + 2 * dx, fwe);
      rp = fit((x + dx < roi_right) ? x + dx : x - 2 * dx, fwe);
      tp = fit((y - dy >= roi_top) ? y - dy : y + 2 * dy, fhe);
      bp = fit((y + dy < roi_bottom) ? y + dy : y - 2 * dy, fhe);
      // The same fallback applies to neighbours that are not inspected.
      if (!map_mem[store_addr(lp, y)]) lp = fit(x + 2 * dx, fwe);
      if (!map_mem[store_addr(rp, y)]) rp = fit(x - 2 * dx, fwe);
      if (!map_mem[store_addr(x, tp)]) tp = fit(y + 2 * dy, fhe);
      if (!map_mem[store_addr(x, bp)]) bp = fit(y - 2 * dy, fhe);
      l  = take_pixel(lp, y);
      r  = take_pixel(rp, y);
      t  = take_pixel(x, tp);
      b  = take_pixel(x, bp);
      lt = take_pixel(lp, tp);
      lb = take_pixel(lp, bp);
      rt = take_pixel(rp, tp);
      rb = take_pixel(rp, bp);
      diff[0] = l - r;   sums[0] = l + r;
      diff[1] = t - b;   sums[1] = t + b;
      diff[2] = lb - rt; sums[2] = lb + rt;
      diff[3] = lt - rb; sums[3] = lt + rb;
      // The first direction with the smallest difference wins.
      best = NO_DIFF;
      pick = 0;
      for (k = 0; k < 4; k++) begin
         mag = (diff[k] < 0) ? -diff[k] : diff[k];
         if (mag < best) begin
            best = mag;
            pick = k;
         end
      end
      acc = MID_LEVEL + 2 * c - sums[pick];
      if (acc < 0) acc = 0;
      if (acc > MAX_LEVEL) acc = MAX_LEVEL;
      res.level = 8'(acc);
      res.direction = DIR_ORDER[pick];
      return res;
   endfunction

   // Rows of the directed table.
   function automatic stim_row_type pixel_row(input int x, input int y, input int v,
                                              input bit f);
      stim_row_type row;
      row = '0;
      row.kind = ROW_WORD;
      row.op = OP_WRITE;
      row.x = 8'(x);
      row.y = 8'(y);
      row.value = 8'(v);
      row.flag = f;
      return row;
   endfunction

   function automatic stim_row_type probe_row(input int x, input int y);
      stim_row_type row;
      row = '0;
      row.kind = ROW_WORD;
      row.op = OP_COMPUTE;
      row.x = 8'(x);
      row.y = 8'(y);
      return row;
   endfunction

   function automatic stim_row_type known_row(input int x, input int y, input logic [7:0] lvl,
                                              input logic [1:0] st, input logic [1:0] dir);
      stim_row_type row;
      row = probe_row(x, y);
      row.known = 1'b1;
      row.want.level = lvl;
      row.want.status = st;
      row.want.direction = dir;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
      stim_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.idx = idx;
      row.data = data;
      return row;
   endfunction

   // Random choices of the random phases.
   function automatic logic [7:0] pick_coord(input int base);
      int r;
      r = $urandom_range(99);
      if (r < 80) return 8'(base + $urandom_range(0, 7));
      if (r < 90) return 8'($urandom_range(0, 255));
      return (r < 95) ? 8'd0 : 8'd255;
   endfunction

   function automatic logic [7:0] pick_level();
      int r;
      r = $urandom_range(99);
      if (r < 15) return (r < 8) ? 8'd0 : 8'd255;
      if (r < 35) return 8'(100 + $urandom_range(0, 3));
      return 8'($urandom);
   endfunction

   function automatic logic [CFG_DATA_W-1:0] pick_extent();
      int r;
      r = $urandom_range(99);
      if (r < 30) return CFG_DATA_W'($urandom_range(8, 40));
      if (r < 60) return CFG_DATA_W'(256);
      if (r < 80) return CFG_DATA_W'($urandom_range(0, 511));
      return CFG_DATA_W'($urandom_range(200, 300));
   endfunction

   function automatic logic [CFG_DATA_W-1:0] pick_pitch();
      int r;
      r = $urandom_range(99);
      if (r < 50) return CFG_DATA_W'($urandom_range(0, 3));
      if (r < 80) return CFG_DATA_W'($urandom_range(0, 12));
      return CFG_DATA_W'($urandom_range(0, 511));
   endfunction

   function automatic logic [CFG_DATA_W-1:0] pick_low_edge(input int base);
      int r;
      r = $urandom_range(99);
      if (r < 40) return '0;
      if (r < 85) return CFG_DATA_W'(base + $urandom_range(0, 4));
      return CFG_DATA_W'($urandom_range(0, 511));
   endfunction

   function automatic logic [CFG_DATA_W-1:0] pick_high_edge(input int base);
      int r;
      r = $urandom_range(99);
      if (r < 40) return CFG_DATA_W'(256);
      if (r < 85) return CFG_DATA_W'(base + $urandom_range(3, 8));
      return CFG_DATA_W'($urandom_range(0, 511));
   endfunction

   // Offers one word and, once it is taken, updates the mirror or queues its result.
   task automatic send_word(input logic op, input logic [7:0] x, input logic [7:0] y,
                            input logic [7:0] v, input logic f,
                            input bit known = 1'b0, input filter_result_type want = '0);
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pixel_value <= v;
      req_inspect_flag <= f;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (op == OP_WRITE) begin
         pixel_mem[store_addr(int'(x), int'(y))] = v;
         map_mem[store_addr(int'(x), int'(y))] = f;
         written[store_addr(int'(x), int'(y))] = 1'b1;
      end else begin
         pending_results.push_back(known ? want : predict_filter(x, y));
      end
   endtask

   // Writes every pixel that a compute at (x, y) would read but that holds no value yet.
   task automatic cover_reads(input logic [7:0] x, input logic [7:0] y);
      filter_result_type probe;
      int  k;
      bit  missing;
      do begin
         probe = predict_filter(x, y);
         missing = 1'b0;
         for (k = 0; k < n_touched; k++) begin
            if (!written[touched[k]]) begin
               missing = 1'b1;
               send_word(OP_WRITE, 8'(touched[k] % MAX_W), 8'(touched[k] / MAX_W),
                         pick_level(), $urandom_range(99) < 75);
            end
         end
      end while (missing);
   endtask

   // Lets every outstanding result word arrive and the block fall idle.
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:   frame_w = int'(data);
         CSR_FRAME_HEIGHT:  frame_h = int'(data);
         CSR_PITCH_X:       step_x = int'(data[7:0]);
         CSR_PITCH_Y:       step_y = int'(data[7:0]);
         CSR_REGION_LEFT:   roi_left = int'(data[7:0]);
         CSR_REGION_TOP:    roi_top = int'(data[7:0]);
         CSR_REGION_RIGHT:  roi_right = int'(data);
         CSR_REGION_BOTTOM: roi_bottom = int'(data);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // The result side stalls at random, except in the calm phase.
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // Each result word taken is compared with the oldest expectation.
   always @(posedge clock) begin : check_results
      filter_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            if (error_count < REPORT_LIMIT)
               $display("unexpected result word: out_value %0d status %0d direction %0d",
                        rsp_out_value, rsp_status, rsp_chosen_direction);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_out_value !== want.level || rsp_status !== want.status ||
                rsp_chosen_direction !== want.direction) begin
               if (error_count < REPORT_LIMIT)
                  $display({"result mismatch (expected/actual): out_value %0d/%0d ",
                            "status %0d/%0d direction %0d/%0d"},
                           want.level, rsp_out_value, want.status, rsp_status,
                           want.direction, rsp_chosen_direction);
               error_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("directional_min_diff_filter_top regression: fail");
      $finish;
   end

   initial begin
      stim_row_type script [SCRIPT_ROWS];
      logic [CFG_DATA_W-1:0] phase_cfg [8];
      logic [7:0] cx, cy;
      int n, len, phase, directed_words, win_x, win_y, eff_w, eff_h;

      // Directed words under the reset configuration: a 3x3 patch around (10, 10)
      // steered through each direction, the upper output clamp and both early exits.
      script = '{
         pixel_row(0, 0, 0, 1'b0),
         known_row(0, 0, 8'd0, STATUS_UNINSPECTED, DIR_H),
         pixel_row(9, 9, 0, 1'b1),   pixel_row(10, 9, 0, 1'b1),
         pixel_row(11, 9, 0, 1'b1),  pixel_row(9, 10, 0, 1'b1),
         pixel_row(11, 10, 0, 1'b1), pixel_row(9, 11, 0, 1'b1),
         pixel_row(10, 11, 0, 1'b1), pixel_row(11, 11, 0, 1'b1),
         pixel_row(10, 10, 255, 1'b1),
         known_row(10, 10, 8'd255, STATUS_OK, DIR_H),
         pixel_row(10, 10, 0, 1'b1),
         known_row(10, 10, 8'd128, STATUS_OK, DIR_H),
         pixel_row(11, 10, 255, 1'b1),
         known_row(10, 10, 8'd128, STATUS_OK, DIR_V),
         pixel_row(10, 9, 255, 1'b1),
         known_row(10, 10, 8'd128, STATUS_OK, DIR_D45),
         pixel_row(9, 11, 200, 1'b0),
         known_row(10, 10, 8'd128, STATUS_OK, DIR_D135),
         pixel_row(11, 10, 255, 1'b0),
         probe_row(10, 10),
         probe_row(255, 255),
         csr_row(CSR_PITCH_Y, 9'd86),
         known_row(0, 0, 8'd0, STATUS_PITCH, DIR_H),
         csr_row(CSR_PITCH_Y, 9'd1)
      };

      // Synchronous reset, released on a falling clock edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            quiesce();
            write_csr(script[i].idx, script[i].data);
         end else begin
            if (script[i].op == OP_COMPUTE) cover_reads(script[i].x, script[i].y);
            send_word(script[i].op, script[i].x, script[i].y, script[i].value, script[i].flag,
                      script[i].known, script[i].want);
         end
      end
      directed_words = words_sent;

      // Random phases, each under its own configuration; the first four are extremes.
      phase = 0;
      while (words_sent < directed_words + RANDOM_WORDS) begin
         calm = (phase == CALM_PHASE);
         len = 110;
         win_x = $urandom_range(0, 248);
         win_y = $urandom_range(0, 248);
         phase_cfg[CSR_FRAME_WIDTH]   = 9'd256;
         phase_cfg[CSR_FRAME_HEIGHT]  = 9'd256;
         phase_cfg[CSR_PITCH_X]       = 9'd1;
         phase_cfg[CSR_PITCH_Y]       = 9'd1;
         phase_cfg[CSR_REGION_LEFT]   = 9'd0;
         phase_cfg[CSR_REGION_TOP]    = 9'd0;
         phase_cfg[CSR_REGION_RIGHT]  = 9'd256;
         phase_cfg[CSR_REGION_BOTTOM] = 9'd256;
         case (phase)
            0: begin
               // Widest frame, largest legal pitch and an inverted region.
               phase_cfg[CSR_FRAME_WIDTH]   = 9'd511;
               phase_cfg[CSR_FRAME_HEIGHT]  = 9'd511;
               phase_cfg[CSR_PITCH_X]       = 9'd170;
               phase_cfg[CSR_PITCH_Y]       = 9'd170;
               phase_cfg[CSR_REGION_LEFT]   = 9'd255;
               phase_cfg[CSR_REGION_TOP]    = 9'd255;
               phase_cfg[CSR_REGION_RIGHT]  = 9'd0;
               phase_cfg[CSR_REGION_BOTTOM] = 9'd0;
            end
            1: begin
               // A one-pixel frame with zero pitch: every read lands on the origin.
               phase_cfg[CSR_FRAME_WIDTH]  = 9'd1;
               phase_cfg[CSR_FRAME_HEIGHT] = 9'd1;
               phase_cfg[CSR_PITCH_X]      = 9'd0;
               phase_cfg[CSR_PITCH_Y]      = 9'd0;
               win_x = 0;
               win_y = 0;
               len = 40;
            end
            2: begin
               // A zero frame width rejects every pitch.
               phase_cfg[CSR_FRAME_WIDTH] = 9'd0;
               len = 30;
            end
            3: begin
               // The top data bit is dropped, leaving the largest pitch.
               phase_cfg[CSR_PITCH_X] = 9'h1FF;
               len = 30;
            end
            default: begin
               phase_cfg[CSR_FRAME_WIDTH]  = pick_extent();
               phase_cfg[CSR_FRAME_HEIGHT] = pick_extent();
               phase_cfg[CSR_PITCH_X]      = pick_pitch();
               phase_cfg[CSR_PITCH_Y]      = pick_pitch();
               eff_w = extent(int'(phase_cfg[CSR_FRAME_WIDTH]), MAX_W);
               eff_h = extent(int'(phase_cfg[CSR_FRAME_HEIGHT]), MAX_H);
               win_x = ($urandom_range(99) < 15) ? 248 :
                       $urandom_range(0, (eff_w > 8) ? eff_w - 8 : 0);
               win_y = ($urandom_range(99) < 15) ? 248 :
                       $urandom_range(0, (eff_h > 8) ? eff_h - 8 : 0);
               phase_cfg[CSR_REGION_LEFT]   = pick_low_edge(win_x);
               phase_cfg[CSR_REGION_TOP]    = pick_low_edge(win_y);
               phase_cfg[CSR_REGION_RIGHT]  = pick_high_edge(win_x);
               phase_cfg[CSR_REGION_BOTTOM] = pick_high_edge(win_y);
            end
         endcase
         quiesce();
         foreach (phase_cfg[k]) write_csr(CFG_IDX_W'(k), phase_cfg[k]);

         // Mostly words clustered in a small window, so that neighbours are inspected.
         for (n = 0; n < len; n++) begin
            if ($urandom_range(99) < 45) begin
               send_word(OP_WRITE, pick_coord(win_x), pick_coord(win_y), pick_level(),
                         $urandom_range(99) < 75);
            end else begin
               cx = pick_coord(win_x);
               cy = pick_coord(win_y);
               cover_reads(cx, cy);
               send_word(OP_COMPUTE, cx, cy, 8'($urandom), 1'($urandom));
            end
         end
         phase++;
      end
      calm = 1'b0;
      quiesce();

      error_count += pending_results.size();
      if (error_count == 0) begin
         $display("directional_min_diff_filter_top regression: pass");
      end else begin
         $display("directional_min_diff_filter_top regression: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/dmdf_pkg.sv
rtl/core/dmdf_store.sv
rtl/core/directional_min_diff_filter_top.sv
rtl/core/dmdf_checker.sv
dv/tb_top.sv
